### src/rslt_pkg.sv
// ----------------------------------------------------------------------------
// Request slot list table package
// Item types, storage entry type and mode/status codes shared by the table.
// ----------------------------------------------------------------------------
package rslt_pkg;

  // Request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_NOT_USED  = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] ip_address;
    logic [15:0] header_bytes;
    logic [31:0] cookie;
    logic [31:0] arrival_time;
    logic [3:0]  slot_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [31:0] entry_address;
    logic [15:0] entry_header;
    logic [31:0] entry_time;
  } out_item_t;

  // One stored request
  typedef struct packed {
    logic [31:0] address;
    logic [15:0] header;
    logic [31:0] cookie;
    logic [31:0] arr_time;
  } entry_t;

endpackage

### src/request_slot_list_table_unit.sv
// ----------------------------------------------------------------------------
// Request slot list table
// Outstanding requests in fixed slots, chained oldest to newest by prev/next
// links. Insert takes the lowest free slot, remove unlinks by index, lookup
// walks from the oldest entry and returns the first cookie match.
// ----------------------------------------------------------------------------
// Insert scans for a free slot; on a non-empty list it then passes through
// S_LINK to link the old tail. Remove reads the slot's links, then unlinks it.
// A remove of a slot not in use, a lookup on an empty list and mode three are
// answered from idle. Lookup walks until a hit or the end of the list.
// One item at a time: busy stays high until the result is registered; the
// free-slot scan checks one used bit and the list walk one RAM slot per cycle.
// The result is shown for one cycle with out_valid; the receiver cannot stall.
// Synchronous reset empties the list; stored request fields are not cleared.
module request_slot_list_table_unit #(
  parameter int SLOTS        = 16,
  parameter int COOKIE_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  rslt_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                out_valid,
  output rslt_pkg::out_item_t out_item
);

  import rslt_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = IDX_W + 1;
  localparam int WIDE_W = IDX_W + 4;
  localparam logic [LINK_W-1:0] NULL_LINK = {1'b1, {IDX_W{1'b0}}};
  localparam logic [31:0] COOKIE_MASK = (COOKIE_BYTES >= 4) ? 32'hFFFF_FFFF :
      32'((64'd1 << (8 * COOKIE_BYTES)) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_LINK   = 5'b00100,
    S_REMOVE = 5'b01000,
    S_WALK   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  in_item_t          req_r, req_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] tail_r, tail_nxt;
  logic [SLOTS-1:0]  used_r, used_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic [IDX_W-1:0]  rd_addr;
  logic              data_we;
  entry_t            data_wd, data_q;
  logic              prev_we, next_we;
  logic [IDX_W-1:0]  prev_wa, next_wa;
  logic [LINK_W-1:0] prev_wd, next_wd, prev_q, next_q;

  logic [WIDE_W-1:0] rm_wide;
  logic              rm_ok;
  logic              cookie_hit;

  function automatic logic [3:0] slot4(input logic [IDX_W-1:0] idx);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(idx);
    return w[3:0];
  endfunction

  function automatic logic [LINK_W-1:0] as_link(input logic [IDX_W-1:0] idx);
    return {1'b0, idx};
  endfunction

  rslt_ram #(.WIDTH($bits(entry_t)), .DEPTH(SLOTS)) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(cur_r),
    .wdata(data_wd),
    .raddr(rd_addr),
    .rdata(data_q)
  );

  rslt_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev_ram (
    .clk  (clk),
    .we   (prev_we),
    .waddr(prev_wa),
    .wdata(prev_wd),
    .raddr(rd_addr),
    .rdata(prev_q)
  );

  rslt_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next_ram (
    .clk  (clk),
    .we   (next_we),
    .waddr(next_wa),
    .wdata(next_wd),
    .raddr(rd_addr),
    .rdata(next_q)
  );

  assign rm_wide    = WIDE_W'(in_item.slot_index);
  assign rm_ok      = (rm_wide < WIDE_W'(SLOTS)) && used_r[rm_wide[IDX_W-1:0]];
  assign cookie_hit = ((data_q.cookie ^ req_r.cookie) & COOKIE_MASK) == 32'd0;

  assign data_wd = '{address:  req_r.ip_address,
                     header:   req_r.header_bytes,
                     cookie:   req_r.cookie,
                     arr_time: req_r.arrival_time};

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cur_nxt       = cur_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    used_nxt      = used_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_addr       = cur_r;
    data_we       = 1'b0;
    prev_we       = 1'b0;
    prev_wa       = cur_r;
    prev_wd       = tail_r;
    next_we       = 1'b0;
    next_wa       = cur_r;
    next_wd       = NULL_LINK;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt      = in_item;
          out_item_nxt = '0;
          case (in_item.mode)
            MODE_INSERT: begin
              cur_nxt   = '0;
              state_nxt = S_SCAN;
            end
            MODE_REMOVE: begin
              if (rm_ok) begin
                // read both links of the slot, unlink next cycle
                cur_nxt   = rm_wide[IDX_W-1:0];
                rd_addr   = rm_wide[IDX_W-1:0];
                state_nxt = S_REMOVE;
              end else begin
                out_item_nxt.status = ST_NOT_USED;
                out_valid_nxt       = 1'b1;
              end
            end
            MODE_LOOKUP: begin
              if (head_r[IDX_W]) begin
                out_item_nxt.status = ST_NOT_FOUND;
                out_valid_nxt       = 1'b1;
              end else begin
                cur_nxt   = head_r[IDX_W-1:0];
                rd_addr   = head_r[IDX_W-1:0];
                state_nxt = S_WALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!used_r[cur_r]) begin
          // claim slot, store the request and make it the new tail
          data_we          = 1'b1;
          prev_we          = 1'b1;
          next_we          = 1'b1;
          used_nxt[cur_r]  = 1'b1;
          if (tail_r[IDX_W]) begin
            head_nxt          = as_link(cur_r);
            tail_nxt          = as_link(cur_r);
            out_item_nxt.slot = slot4(cur_r);
            out_valid_nxt     = 1'b1;
            state_nxt         = S_IDLE;
          end else begin
            state_nxt = S_LINK;
          end
        end else if (cur_r == LAST_SLOT) begin
          out_item_nxt.status = ST_FULL;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end

      S_LINK: begin
        next_we           = 1'b1;
        next_wa           = tail_r[IDX_W-1:0];
        next_wd           = as_link(cur_r);
        tail_nxt          = as_link(cur_r);
        out_item_nxt.slot = slot4(cur_r);
        out_valid_nxt     = 1'b1;
        state_nxt         = S_IDLE;
      end

      S_REMOVE: begin
        if (prev_q[IDX_W]) begin
          head_nxt = next_q;
        end else begin
          next_we = 1'b1;
          next_wa = prev_q[IDX_W-1:0];
          next_wd = next_q;
        end
        if (next_q[IDX_W]) begin
          tail_nxt = prev_q;
        end else begin
          prev_we = 1'b1;
          prev_wa = next_q[IDX_W-1:0];
          prev_wd = prev_q;
        end
        used_nxt[cur_r] = 1'b0;
        out_valid_nxt   = 1'b1;
        state_nxt       = S_IDLE;
      end

      S_WALK: begin
        if (cookie_hit) begin
          out_item_nxt.slot          = slot4(cur_r);
          out_item_nxt.entry_address = data_q.address;
          out_item_nxt.entry_header  = data_q.header;
          out_item_nxt.entry_time    = data_q.arr_time;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end else if (next_q[IDX_W]) begin
          out_item_nxt.status = ST_NOT_FOUND;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end else begin
          // follow the link straight from the RAM output
          cur_nxt = next_q[IDX_W-1:0];
          rd_addr = next_q[IDX_W-1:0];
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NULL_LINK;
      tail_r      <= NULL_LINK;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    cur_r      <= cur_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### src/rslt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rslt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### verif/request_slot_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request slot list table checker
// Watches the command and result channels of the table. Keeps its own copy
// of the slot table and list links, predicts the result of every accepted
// item and compares each strobed result, field by field, against the oldest
// expectation.
// ----------------------------------------------------------------------------
module request_slot_list_checker #(
  parameter int SLOTS        = 16,
  parameter int COOKIE_BYTES = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  rslt_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  rslt_pkg::out_item_t out_item,
  output int                  mismatches,
  output int                  pending
);
  import rslt_pkg::*;

  localparam logic [4:0] NO_SLOT = 5'h1F;

  logic       slot_used [SLOTS];
  logic [4:0] prev_lnk  [SLOTS];
  logic [4:0] next_lnk  [SLOTS];
  logic [4:0] head_lnk;
  logic [4:0] tail_lnk;
  entry_t     slot_store [SLOTS];

  out_item_t  expected_results [$];

  function automatic out_item_t predict_result(input in_item_t it);
    out_item_t   r;
    int          free_idx;
    logic [4:0]  cur;
    logic [4:0]  p;
    logic [4:0]  n;
    logic [31:0] mask;
    logic        found;
    int          i;
    r = '0;
    mask = (COOKIE_BYTES >= 4) ? 32'hFFFF_FFFF : (32'd1 << (COOKIE_BYTES * 8)) - 32'd1;
    case (it.mode)
      MODE_INSERT: begin
        free_idx = -1;
        for (i = 0; i < SLOTS; i++)
          if (!slot_used[i] && free_idx < 0) free_idx = i;
        if (free_idx < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_store[free_idx] = '{address: it.ip_address, header: it.header_bytes,
                                   cookie: it.cookie, arr_time: it.arrival_time};
          if (tail_lnk == NO_SLOT) head_lnk = free_idx[4:0];
          else next_lnk[tail_lnk] = free_idx[4:0];
          prev_lnk[free_idx]  = tail_lnk;
          next_lnk[free_idx]  = NO_SLOT;
          tail_lnk            = free_idx[4:0];
          slot_used[free_idx] = 1'b1;
          r.slot              = free_idx[3:0];
        end
      end
      MODE_REMOVE: begin
        if (int'(it.slot_index) >= SLOTS || !slot_used[it.slot_index]) begin
          r.status = ST_NOT_USED;
        end else begin
          p = prev_lnk[it.slot_index];
          n = next_lnk[it.slot_index];
          if (p == NO_SLOT) head_lnk = n;
          else next_lnk[p] = n;
          if (n == NO_SLOT) tail_lnk = p;
          else prev_lnk[n] = p;
          prev_lnk[it.slot_index]  = NO_SLOT;
          next_lnk[it.slot_index]  = NO_SLOT;
          slot_used[it.slot_index] = 1'b0;
        end
      end
      MODE_LOOKUP: begin
        cur   = head_lnk;
        found = 1'b0;
        // walk oldest to newest, bounded by the table size
        for (i = 0; i < SLOTS && !found && cur != NO_SLOT && cur < SLOTS; i++) begin
          if (slot_used[cur] && ((slot_store[cur].cookie ^ it.cookie) & mask) == 32'd0) begin
            found           = 1'b1;
            r.slot          = cur[3:0];
            r.entry_address = slot_store[cur].address;
            r.entry_header  = slot_store[cur].header;
            r.entry_time    = slot_store[cur].arr_time;
          end else begin
            cur = next_lnk[cur];
          end
        end
        if (!found) r.status = ST_NOT_FOUND;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        prev_lnk[i]  = NO_SLOT;
        next_lnk[i]  = NO_SLOT;
      end
      head_lnk = NO_SLOT;
      tail_lnk = NO_SLOT;
      expected_results.delete();
      mismatches = 0;
    end else begin
      // retire the oldest expectation before taking a new item at the same edge
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status=%0d slot=%0d addr=%h hdr=%h time=%h",
                     out_item.status, out_item.slot, out_item.entry_address,
                     out_item.entry_header, out_item.entry_time);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.status != out_item.status || exp_r.slot != out_item.slot ||
              exp_r.entry_address != out_item.entry_address ||
              exp_r.entry_header != out_item.entry_header ||
              exp_r.entry_time != out_item.entry_time) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected status=%0d slot=%0d addr=%h hdr=%h time=%h, got status=%0d slot=%0d addr=%h hdr=%h time=%h",
                       exp_r.status, exp_r.slot, exp_r.entry_address, exp_r.entry_header,
                       exp_r.entry_time, out_item.status, out_item.slot,
                       out_item.entry_address, out_item.entry_header, out_item.entry_time);
          end
        end
      end
      if (start && !busy) expected_results.push_back(predict_result(in_item));
    end
    pending = expected_results.size();
  end

endmodule

### verif/tb_request_slot_list_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request slot list table testbench
// Drives directed and random insert, remove and lookup commands into the
// table with random sender gaps; a checker beside the block predicts and
// compares every result and reports its failure count for the verdict.
// ----------------------------------------------------------------------------
module tb_request_slot_list_table_unit;
  import rslt_pkg::*;

  localparam int SLOTS        = 16;
  localparam int COOKIE_BYTES = 4;
  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  int          mismatches;
  int          pending;
  int          cycles = 0;
  bit          no_idle = 1'b0;
  logic [31:0] cookie_pool [8];

  always #6 clk = ~clk;

  request_slot_list_table_unit #(
    .SLOTS       (SLOTS),
    .COOKIE_BYTES(COOKIE_BYTES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  request_slot_list_checker #(
    .SLOTS       (SLOTS),
    .COOKIE_BYTES(COOKIE_BYTES)
  ) chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Hold the command until the table takes it; busy is sampled mid-cycle.
  task automatic send_item(input in_item_t it);
    logic was_busy;
    int   gap;
    if (!no_idle && $urandom_range(0, 99) < 18) begin
      gap = $urandom_range(1, 20);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    do begin
      @(negedge clk);
      start    <= 1'b1;
      in_item  <= it;
      was_busy = busy;
      @(posedge clk);
    end while (was_busy);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_cookie();
    if ($urandom_range(0, 99) < 80) return cookie_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic in_item_t make_item(input logic [1:0] mode, input logic [31:0] cookie,
                                         input int unsigned idx);
    in_item_t it;
    it.mode         = mode;
    it.ip_address   = $urandom;
    it.header_bytes = 16'($urandom_range(0, 65535));
    it.cookie       = cookie;
    it.arrival_time = $urandom;
    it.slot_index   = 4'(idx);
    return it;
  endfunction

  initial begin
    in_item_t it;
    int       r;
    for (int i = 0; i < 8; i++) cookie_pool[i] = $urandom;
    cookie_pool[0] = 32'hFFFF_FFFF;
    cookie_pool[1] = 32'h0000_0000;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // empty table: lookup miss, remove of a free slot, unused mode
    send_item(make_item(MODE_LOOKUP, cookie_pool[0], $urandom_range(0, 15)));
    send_item(make_item(MODE_REMOVE, $urandom, 15));
    send_item('1);
    // fill every slot, first with all-zero fields, then all-one fields
    send_item('0);
    it = '1;
    it.mode = MODE_INSERT;
    send_item(it);
    for (int i = 2; i < SLOTS; i++)
      send_item(make_item(MODE_INSERT, pick_cookie(), $urandom_range(0, 15)));
    send_item(make_item(MODE_INSERT, $urandom, $urandom_range(0, 15)));
    send_item(make_item(MODE_LOOKUP, 32'hFFFF_FFFF, $urandom_range(0, 15)));
    send_item(make_item(MODE_LOOKUP, $urandom, $urandom_range(0, 15)));
    // unlink at the head, the tail and the middle, then a stale remove
    send_item(make_item(MODE_REMOVE, $urandom, 0));
    send_item(make_item(MODE_REMOVE, $urandom, 15));
    send_item(make_item(MODE_REMOVE, $urandom, 7));
    send_item(make_item(MODE_REMOVE, $urandom, 7));
    drain_results();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      no_idle = (k >= 240 && k < 360);
      r = $urandom_range(0, 99);
      // alternate fill-heavy and drain-heavy stretches to reach full and empty
      if ((k / 60) % 2 == 0) begin
        if (r < 55)      it = make_item(MODE_INSERT, pick_cookie(), $urandom_range(0, 15));
        else if (r < 75) it = make_item(MODE_REMOVE, pick_cookie(), $urandom_range(0, 15));
        else if (r < 97) it = make_item(MODE_LOOKUP, pick_cookie(), $urandom_range(0, 15));
        else             it = make_item(2'b11, pick_cookie(), $urandom_range(0, 15));
      end else begin
        if (r < 20)      it = make_item(MODE_INSERT, pick_cookie(), $urandom_range(0, 15));
        else if (r < 65) it = make_item(MODE_REMOVE, pick_cookie(), $urandom_range(0, 15));
        else if (r < 97) it = make_item(MODE_LOOKUP, pick_cookie(), $urandom_range(0, 15));
        else             it = make_item(2'b11, pick_cookie(), $urandom_range(0, 15));
      end
      send_item(it);
      if (k % 150 == 149) drain_results();
    end

    drain_results();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### request_slot_list_table_unit.f
src/rslt_pkg.sv
src/rslt_ram.sv
src/request_slot_list_table_unit.sv
verif/request_slot_list_checker.sv
verif/tb_request_slot_list_table_unit.sv
